>>> design/printable_caesar_xor_hex_codec_top_defines.svh
// Assertion macros shared by the codec checker.
`ifndef PRINTABLE_CAESAR_XOR_HEX_CODEC_TOP_DEFINES_SVH
`define PRINTABLE_CAESAR_XOR_HEX_CODEC_TOP_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define PCX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PCX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/pcx_pkg.sv
// Shared types, character codes and helpers for the printable Caesar / XOR hex codec.
`timescale 1ns / 1ps
package pcx_pkg;

  localparam int unsigned AddrWidth = 4;

  localparam logic [1:0] REG_SHIFT_KEY   = 2'd0;
  localparam logic [1:0] REG_CIPHER_MODE = 2'd1;
  localparam logic [1:0] REG_ENCRYPT_DIR = 2'd2;

  localparam logic [7:0] PR_LOW    = 8'd32;
  localparam logic [7:0] PR_HIGH   = 8'd126;
  localparam logic [7:0] PR_SPAN   = 8'd95;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;

  typedef struct packed {
    logic [6:0] shift_key;
    logic       cipher_mode;
    logic       encrypt_direction;
  } cfg_t;

  typedef enum logic {
    KIND_CHAR,
    KIND_HEX
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
  } item_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD_ZERO,
    PH_DIGITS,
    PH_STOP
  } parse_phase_e;

  typedef enum logic [2:0] {
    HS_OPEN,
    HS_ZERO,
    HS_X,
    HS_PAD,
    HS_HI,
    HS_LO,
    HS_CLOSE
  } hex_step_e;

  // Lowercase hex digit for a nibble.
  function automatic logic [7:0] hex_digit(logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'b0, nib};
    end else begin
      ch = CH_LOW_A + {4'b0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage

>>> design/pcx_front.sv
// Front end: accepts input beats, runs the Caesar map, the XOR mask and the hex parser, queues work.
`timescale 1ns / 1ps
module pcx_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcx_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    char_in_i,
  input  logic          string_end_i,
  input  logic          full_i,
  output logic          push_o,
  output pcx_pkg::item_t item_o
);

  logic                  inside_q, inside_d;
  logic [7:0]            accum_q, accum_d;
  pcx_pkg::parse_phase_e phase_q, phase_d;

  logic       accept;
  logic       is_hex;
  logic [3:0] digit;
  logic [6:0] key_eff;
  logic [8:0] rot;
  logic [7:0] caesar;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    is_hex = 1'b1;
    digit  = char_in_i[3:0];
    if (char_in_i >= pcx_pkg::CH_ZERO && char_in_i <= pcx_pkg::CH_NINE) begin
      digit = char_in_i[3:0];
    end else if ((char_in_i >= pcx_pkg::CH_LOW_A && char_in_i <= pcx_pkg::CH_LOW_F) ||
                 (char_in_i >= pcx_pkg::CH_UP_A && char_in_i <= pcx_pkg::CH_UP_F)) begin
      digit = char_in_i[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Key of 95 and above folds back into the printable span.
  always_comb begin
    key_eff = (cfg_i.shift_key >= pcx_pkg::PR_SPAN[6:0]) ?
              cfg_i.shift_key - pcx_pkg::PR_SPAN[6:0] : cfg_i.shift_key;
    if (cfg_i.encrypt_direction) begin
      rot = {1'b0, char_in_i} + {2'b0, key_eff};
    end else begin
      rot = {1'b0, char_in_i} + {1'b0, pcx_pkg::PR_SPAN} - {2'b0, key_eff};
    end
    if (rot > {1'b0, pcx_pkg::PR_HIGH}) begin
      rot = rot - {1'b0, pcx_pkg::PR_SPAN};
    end
    if (char_in_i >= pcx_pkg::PR_LOW && char_in_i <= pcx_pkg::PR_HIGH) begin
      caesar = rot[7:0];
    end else begin
      caesar = char_in_i;
    end
  end

  always_comb begin
    inside_d = inside_q;
    accum_d  = accum_q;
    phase_d  = phase_q;
    push_o   = 1'b0;
    item_o.kind  = pcx_pkg::KIND_CHAR;
    item_o.value = caesar;

    if (!cfg_i.cipher_mode) begin
      push_o = accept;
    end else if (cfg_i.encrypt_direction) begin
      push_o       = accept;
      item_o.kind  = pcx_pkg::KIND_HEX;
      item_o.value = char_in_i ^ {1'b0, cfg_i.shift_key};
    end else if (char_in_i == pcx_pkg::CH_LBRACK) begin
      inside_d = 1'b1;
    end else if (char_in_i == pcx_pkg::CH_RBRACK) begin
      push_o       = accept;
      item_o.value = accum_q ^ {1'b0, cfg_i.shift_key};
      inside_d     = 1'b0;
      accum_d      = '0;
      phase_d      = pcx_pkg::PH_IDLE;
    end else if (inside_q) begin
      case (phase_q)
        pcx_pkg::PH_IDLE: begin
          if (!is_hex) begin
            phase_d = pcx_pkg::PH_STOP;
          end else begin
            accum_d = {4'b0, digit};
            phase_d = (digit == 4'd0) ? pcx_pkg::PH_LEAD_ZERO : pcx_pkg::PH_DIGITS;
          end
        end
        pcx_pkg::PH_LEAD_ZERO: begin
          if (char_in_i == pcx_pkg::CH_LOW_X || char_in_i == pcx_pkg::CH_UP_X) begin
            phase_d = pcx_pkg::PH_DIGITS;
          end else if (!is_hex) begin
            phase_d = pcx_pkg::PH_STOP;
          end else begin
            accum_d = {4'b0, digit};
            phase_d = pcx_pkg::PH_DIGITS;
          end
        end
        pcx_pkg::PH_DIGITS: begin
          if (!is_hex) begin
            phase_d = pcx_pkg::PH_STOP;
          end else begin
            accum_d = {accum_q[3:0], digit};
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    if (string_end_i) begin
      inside_d = 1'b0;
      accum_d  = '0;
      phase_d  = pcx_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      accum_q  <= '0;
      phase_q  <= pcx_pkg::PH_IDLE;
    end else if (accept) begin
      inside_q <= inside_d;
      accum_q  <= accum_d;
      phase_q  <= phase_d;
    end
  end

endmodule

>>> design/pcx_fifo.sv
// Work queue between the front end and the byte emitter.
`timescale 1ns / 1ps
module pcx_fifo #(
  parameter int unsigned Depth = 4  // at least 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pcx_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output pcx_pkg::item_t head_o,
  output logic           head_valid_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  pcx_pkg::item_t  mem_q [Depth];
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> design/pcx_back.sv
// Back end: turns queued work into output beats, one byte per beat.
`timescale 1ns / 1ps
module pcx_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcx_pkg::item_t head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     char_out_o,
  output logic           run_last_o
);

  pcx_pkg::hex_step_e step_q, step_d, step_nxt;
  logic       out_valid_q, out_valid_d;
  logic [7:0] char_q;
  logic       last_q;
  logic       load;
  logic [7:0] byte_sel;
  logic       last_sel;

  // Output register refills in the same cycle it is drained.
  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    byte_sel = head_i.value;
    last_sel = 1'b1;
    step_nxt = pcx_pkg::HS_OPEN;
    if (head_i.kind == pcx_pkg::KIND_HEX) begin
      last_sel = 1'b0;
      case (step_q)
        pcx_pkg::HS_OPEN: begin
          byte_sel = pcx_pkg::CH_LBRACK;
          step_nxt = pcx_pkg::HS_ZERO;
        end
        pcx_pkg::HS_ZERO: begin
          byte_sel = pcx_pkg::CH_ZERO;
          step_nxt = pcx_pkg::HS_X;
        end
        pcx_pkg::HS_X: begin
          byte_sel = pcx_pkg::CH_LOW_X;
          step_nxt = pcx_pkg::HS_PAD;
        end
        pcx_pkg::HS_PAD: begin
          // high digit only when the value needs two digits
          byte_sel = pcx_pkg::CH_ZERO;
          step_nxt = (head_i.value[7:4] != 4'd0) ? pcx_pkg::HS_HI : pcx_pkg::HS_LO;
        end
        pcx_pkg::HS_HI: begin
          byte_sel = pcx_pkg::hex_digit(head_i.value[7:4]);
          step_nxt = pcx_pkg::HS_LO;
        end
        pcx_pkg::HS_LO: begin
          byte_sel = pcx_pkg::hex_digit(head_i.value[3:0]);
          step_nxt = pcx_pkg::HS_CLOSE;
        end
        pcx_pkg::HS_CLOSE: begin
          byte_sel = pcx_pkg::CH_RBRACK;
          last_sel = 1'b1;
          step_nxt = pcx_pkg::HS_OPEN;
        end
        default: begin
          byte_sel = pcx_pkg::CH_LBRACK;
          step_nxt = pcx_pkg::HS_OPEN;
        end
      endcase
    end
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    if (load) begin
      step_d      = step_nxt;
      out_valid_d = 1'b1;
      pop_o       = last_sel;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= pcx_pkg::HS_OPEN;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= byte_sel;
      last_q <= last_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign run_last_o  = last_q;

endmodule

>>> design/printable_caesar_xor_hex_codec_top.sv
// Printable Caesar / XOR hex text codec: top level with APB register file.
//
// Input stream: one text byte per beat, tlast marks the end of a string.
// Output stream: produced text bytes, tlast on the final byte made by one input.
// APB registers: 0x0 shift_key, 0x4 cipher_mode, 0x8 encrypt_direction; write them
// only while no beat is in flight.
// Caesar mode: one output byte per input byte. XOR encrypt: six or seven output
// bytes "[0x0..]" per input byte. XOR decrypt: hex text between brackets is parsed,
// one byte per closing bracket, all other bytes give no output.
// Path: an accepted input byte is written into the queue, then loaded into the output register.
// Throughput: one input per cycle while the queue has room and output bytes flow one
// per cycle; the back end emits one byte per cycle, so XOR encrypt input waits on its output bytes.
// A QueueDepth-entry queue sits between front and back; when the sink stalls the
// output register holds its beat, the queue fills and then s_axis_tready drops.
// Reset: shift_key 0, Caesar mode, encrypt; parser cleared, queue and output empty.
`timescale 1ns / 1ps
module printable_caesar_xor_hex_codec_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] char_in
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] char_out
  output logic                           m_axis_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcx_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  pcx_pkg::cfg_t  cfg_q;
  pcx_pkg::item_t push_item, head_item;
  logic           push, pop, full, head_valid;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shift_key         <= '0;
      cfg_q.cipher_mode       <= 1'b0;
      cfg_q.encrypt_direction <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        pcx_pkg::REG_SHIFT_KEY:   cfg_q.shift_key         <= pwdata[6:0];
        pcx_pkg::REG_CIPHER_MODE: cfg_q.cipher_mode       <= pwdata[0];
        pcx_pkg::REG_ENCRYPT_DIR: cfg_q.encrypt_direction <= pwdata[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pcx_pkg::REG_SHIFT_KEY:   prdata = {25'b0, cfg_q.shift_key};
      pcx_pkg::REG_CIPHER_MODE: prdata = {31'b0, cfg_q.cipher_mode};
      pcx_pkg::REG_ENCRYPT_DIR: prdata = {31'b0, cfg_q.encrypt_direction};
      default:                  prdata = '0;
    endcase
  end

  pcx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .char_in_i    (s_axis_tdata),
    .string_end_i (s_axis_tlast),
    .full_i       (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  pcx_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (push_item),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head_item),
    .head_valid_o (head_valid)
  );

  pcx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .char_out_o   (m_axis_tdata),
    .run_last_o   (m_axis_tlast)
  );

endmodule

>>> design/pcx_checker.sv
// Port-level assertions for the codec top, bound in below.
`timescale 1ns / 1ps
`include "printable_caesar_xor_hex_codec_top_defines.svh"
module pcx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       pready
);

  // A stalled output beat keeps its contents.
  `PCX_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed under stall")

  // Input back-pressure only comes while an output beat is pending.
  `PCX_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid, "input stalled with empty output")

  // Bytes of one run leave without gaps.
  `PCX_ASSERT(a_run_gapless, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "gap inside a run")

  `PCX_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

bind printable_caesar_xor_hex_codec_top pcx_checker u_pcx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);

>>> tb/tb_printable_caesar_xor_hex_codec_top.sv
// Self-checking testbench for the printable Caesar / XOR hex text codec top level.
`timescale 1ns / 1ps
module tb_printable_caesar_xor_hex_codec_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;  // [7:0] char_in
  logic                          s_axis_tlast;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;  // [7:0] char_out
  logic                          m_axis_tlast;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [pcx_pkg::AddrWidth-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  // Predictor copy of the registers and the hex parser.
  logic [6:0]            cfg_key;
  logic                  cfg_mode;
  logic                  cfg_dir;
  logic                  in_bracket;
  logic [7:0]            hex_acc;
  pcx_pkg::parse_phase_e phase;

  text_beat_t pending_text[$];
  text_beat_t got_beat;
  int         result_cnt;
  int         mismatch_cnt;
  int         cycle_cnt;
  int         stall_left;
  bit         stall_en;
  bit         gap_en;

  printable_caesar_xor_hex_codec_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    logic [7:0] base;
    base = upper ? pcx_pkg::CH_UP_A : pcx_pkg::CH_LOW_A;
    if (nib < 4'd10) return pcx_pkg::CH_ZERO + {4'b0, nib};
    return base + {4'b0, nib} - 8'd10;
  endfunction

  function automatic int hex_nibble(input logic [7:0] ch);
    if (ch >= pcx_pkg::CH_ZERO && ch <= pcx_pkg::CH_NINE) return int'(ch - pcx_pkg::CH_ZERO);
    if (ch >= pcx_pkg::CH_LOW_A && ch <= pcx_pkg::CH_LOW_F) begin
      return int'(ch - pcx_pkg::CH_LOW_A) + 10;
    end
    if (ch >= pcx_pkg::CH_UP_A && ch <= pcx_pkg::CH_UP_F) return int'(ch - pcx_pkg::CH_UP_A) + 10;
    return -1;
  endfunction

  function automatic void clear_parser();
    in_bracket = 1'b0;
    hex_acc    = 8'd0;
    phase      = pcx_pkg::PH_IDLE;
  endfunction

  function automatic void parse_hex_char(input logic [7:0] ch);
    int d;
    d = hex_nibble(ch);
    case (phase)
      pcx_pkg::PH_IDLE: begin
        if (d < 0) begin
          phase = pcx_pkg::PH_STOP;
        end else begin
          hex_acc = d[7:0];
          phase   = (d == 0) ? pcx_pkg::PH_LEAD_ZERO : pcx_pkg::PH_DIGITS;
        end
      end
      pcx_pkg::PH_LEAD_ZERO: begin
        if (ch == pcx_pkg::CH_LOW_X || ch == pcx_pkg::CH_UP_X) begin
          phase = pcx_pkg::PH_DIGITS;
        end else if (d < 0) begin
          phase = pcx_pkg::PH_STOP;
        end else begin
          hex_acc = d[7:0];
          phase   = pcx_pkg::PH_DIGITS;
        end
      end
      pcx_pkg::PH_DIGITS: begin
        if (d < 0) phase = pcx_pkg::PH_STOP;
        else hex_acc = {hex_acc[3:0], d[3:0]};
      end
      default: ;
    endcase
  endfunction

  // Works out the text bytes one accepted input byte produces.
  function automatic void codec_predict(input logic [7:0] ch, input logic end_mark);
    logic [7:0] txt[7];
    int         n;
    logic [7:0] rot_key;
    logic [7:0] masked;
    logic [8:0] sum;
    text_beat_t beat;
    n = 0;
    if (!cfg_mode) begin
      rot_key = (cfg_key >= 7'd95) ? {1'b0, cfg_key} - pcx_pkg::PR_SPAN : {1'b0, cfg_key};
      txt[0]  = ch;
      if (ch >= pcx_pkg::PR_LOW && ch <= pcx_pkg::PR_HIGH) begin
        if (cfg_dir) sum = {1'b0, ch} + {1'b0, rot_key};
        else sum = {1'b0, ch} + {1'b0, pcx_pkg::PR_SPAN} - {1'b0, rot_key};
        if (sum > {1'b0, pcx_pkg::PR_HIGH}) sum = sum - {1'b0, pcx_pkg::PR_SPAN};
        txt[0] = sum[7:0];
      end
      n = 1;
    end else if (cfg_dir) begin
      masked = ch ^ {1'b0, cfg_key};
      txt[0] = pcx_pkg::CH_LBRACK;
      txt[1] = pcx_pkg::CH_ZERO;
      txt[2] = pcx_pkg::CH_LOW_X;
      txt[3] = pcx_pkg::CH_ZERO;
      n = 4;
      if (masked >= 8'd16) begin
        txt[n] = hex_char(masked[7:4], 1'b0);
        n++;
      end
      txt[n] = hex_char(masked[3:0], 1'b0);
      txt[n+1] = pcx_pkg::CH_RBRACK;
      n += 2;
    end else begin
      if (ch == pcx_pkg::CH_LBRACK) begin
        in_bracket = 1'b1;
      end else if (ch == pcx_pkg::CH_RBRACK) begin
        txt[0] = hex_acc ^ {1'b0, cfg_key};
        n = 1;
        clear_parser();
      end else if (in_bracket) begin
        parse_hex_char(ch);
      end
    end
    for (int i = 0; i < n; i++) begin
      beat.ch   = txt[i];
      beat.last = (i == n - 1);
      pending_text.push_back(beat);
    end
    result_cnt += n;
    if (end_mark) clear_parser();
  endfunction

  // Output side: random backpressure bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_en && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare every output beat with the oldest expected byte.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_text.size() == 0) begin
        $error("unexpected output beat: char_out 0x%02h run_last %0b",
               m_axis_tdata, m_axis_tlast);
        mismatch_cnt++;
      end else begin
        got_beat = pending_text.pop_front();
        if (m_axis_tdata !== got_beat.ch) begin
          $error("char_out mismatch: expected 0x%02h, actual 0x%02h",
                 got_beat.ch, m_axis_tdata);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== got_beat.last) begin
          $error("run_last mismatch: expected %0b, actual %0b", got_beat.last, m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_codec_cfg(input logic [6:0] key, input logic mode, input logic dir);
    apb_write(pcx_pkg::REG_SHIFT_KEY, {25'd0, key});
    cfg_key = key;
    apb_write(pcx_pkg::REG_CIPHER_MODE, {31'd0, mode});
    cfg_mode = mode;
    apb_write(pcx_pkg::REG_ENCRYPT_DIR, {31'd0, dir});
    cfg_dir = dir;
  endtask

  task automatic send_beat(input logic [7:0] ch, input logic end_mark);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= end_mark;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    codec_predict(ch, end_mark);
  endtask

  task automatic send_text(input string txt, input bit end_mark);
    for (int i = 0; i < txt.len(); i++) begin
      send_beat(txt[i], end_mark && (i == txt.len() - 1));
    end
  endtask

  // Decrypt may still be busy on a byte with no output, so idle a bit more.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One bracketed hex field with random prefix, digits and case; broken ones
  // lose the closing bracket and end the string instead.
  task automatic send_hex_token(input bit broken);
    logic [7:0] seq[$];
    int         ndig;
    seq.push_back(pcx_pkg::CH_LBRACK);
    case ($urandom_range(0, 3))
      1: begin
        seq.push_back(pcx_pkg::CH_ZERO);
        seq.push_back(pcx_pkg::CH_LOW_X);
      end
      2: begin
        seq.push_back(pcx_pkg::CH_ZERO);
        seq.push_back(pcx_pkg::CH_UP_X);
      end
      3: seq.push_back(pcx_pkg::CH_ZERO);
      default: ;
    endcase
    ndig = $urandom_range(0, 3);
    repeat (ndig) seq.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    if ($urandom_range(0, 4) == 0) begin
      seq.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) seq.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
    end
    if (!broken) seq.push_back(pcx_pkg::CH_RBRACK);
    for (int i = 0; i < seq.size(); i++) begin
      if (i == seq.size() - 1) send_beat(seq[i], broken || ($urandom_range(0, 7) == 0));
      else send_beat(seq[i], 1'b0);
    end
  endtask

  task automatic test_reset_defaults();
    // Caesar, key 0, encrypt: bytes pass straight through
    send_beat(8'h41, 1'b0);
    send_beat(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_caesar_edges();
    write_codec_cfg(7'd94, 1'b0, 1'b1);
    send_beat(8'h20, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h1F, 1'b1);
    wait_drained();
    // key above the span folds back by 95
    write_codec_cfg(7'd127, 1'b0, 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(8'h7F, 1'b1);
    wait_drained();
  endtask

  task automatic test_xor_encrypt_edges();
    write_codec_cfg(7'd0, 1'b1, 1'b1);
    send_beat(8'h0F, 1'b0);
    send_beat(8'h10, 1'b0);
    wait_drained();
    write_codec_cfg(7'd127, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h7F, 1'b1);
    wait_drained();
  endtask

  task automatic test_xor_decrypt_parsing();
    write_codec_cfg(7'h2A, 1'b1, 1'b0);
    send_text("]", 1'b0);
    send_text("[0X1f]", 1'b0);
    send_text("[[g7]", 1'b0);
    send_text("[abc]", 1'b0);
    // parser state survives a register write
    send_text("[1", 1'b0);
    wait_drained();
    write_codec_cfg(7'h55, 1'b1, 1'b0);
    send_text("2]", 1'b0);
    // string end drops the half-parsed field
    send_text("[3", 1'b1);
    send_text("]", 1'b1);
    wait_drained();
  endtask

  task automatic run_random_phase(input logic [6:0] key, input logic mode, input logic dir,
                                  input int amount);
    int start_cnt;
    int pick;
    wait_drained();
    write_codec_cfg(key, mode, dir);
    if (mode && !dir) begin
      start_cnt = result_cnt;
      while (result_cnt - start_cnt < amount) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) send_hex_token(1'b0);
        else if (pick == 7) send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        else if (pick == 8) send_hex_token(1'b1);
        else send_beat(pcx_pkg::CH_RBRACK, 1'b0);
      end
    end else begin
      repeat (amount) send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(7'd0, 1'b0, 1'b1, 50);
    run_random_phase(7'd94, 1'b0, 1'b0, 50);
    run_random_phase(7'd127, 1'b0, 1'b1, 40);
    run_random_phase(7'($urandom_range(0, 127)), 1'b0, 1'b0, 40);
    run_random_phase(7'd0, 1'b1, 1'b1, 30);
    run_random_phase(7'd127, 1'b1, 1'b1, 30);
    run_random_phase(7'($urandom_range(0, 127)), 1'b1, 1'b0, 15);
    run_random_phase(7'd127, 1'b1, 1'b0, 15);
    run_random_phase(7'd0, 1'b1, 1'b0, 10);
    // full rate to the end
    gap_en   = 1'b0;
    stall_en = 1'b0;
    run_random_phase(7'($urandom_range(0, 127)), 1'b1, 1'b1, 30);
    run_random_phase(7'($urandom_range(0, 127)), 1'b0, 1'b1, 50);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = 32'd0;
    cfg_key       = 7'd0;
    cfg_mode      = 1'b0;
    cfg_dir       = 1'b1;
    result_cnt    = 0;
    mismatch_cnt  = 0;
    stall_en      = 1'b1;
    gap_en        = 1'b1;
    clear_parser();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_caesar_edges();
    test_xor_encrypt_edges();
    test_xor_decrypt_parsing();
    test_random_traffic();
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
